// ===== hdl/chbp_pkg.sv =====
// ============================================================================
// Canonical Huffman bit packer: shared package
// Sizes, opcodes, and the command and status bundles that pass between
// the controller and the datapath.
// ============================================================================
package chbp_pkg;

  // Table and code sizes.
  localparam int MAX_CODE_BITS   = 24;
  localparam int NUM_SYMBOLS     = 257;
  localparam int END_SYMBOL      = NUM_SYMBOLS - 1;
  localparam int SYM_W           = $clog2(NUM_SYMBOLS);
  localparam int LEN_W           = 5;
  localparam int BYTE_BITS       = 8;
  localparam int MAX_LEVEL_RESET = 24;

  // Bit accumulator: up to seven leftover bits plus one code plus padding.
  localparam int ACC_W  = MAX_CODE_BITS + BYTE_BITS;
  localparam int PEND_W = $clog2(ACC_W + 1);
  localparam int PAD_W  = $clog2(BYTE_BITS);

  // Rebuild counter: grows by at most NUM_SYMBOLS per level, halved after each.
  localparam int CNT_W = $clog2(2 * NUM_SYMBOLS) + 1;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic scan_rst;   // symbol scan counter back to zero
    logic scan_inc;   // next symbol
    logic clr_wr;     // write zero to the length table at the scan address
    logic load_wr;    // write the input length to the length table
    logic item_load;  // capture the input beat
    logic lvl_init;   // start a rebuild at the top level
    logic lvl_next;   // step down one level and halve the counter
    logic rb_wr;      // assign a code if the length matches the level
    logic lookup;     // read both tables for the captured symbol
    logic append;     // append the looked-up code to the accumulator
    logic emit;       // move one byte into the output register
  } chbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;  // scan address is the last symbol
    logic lvl_zero;   // no level left to assign
    logic pend_ge8;   // a whole byte is pending
    logic last_byte;  // the pending byte is the final one of this item
    logic out_free;   // output register can take a byte this cycle
  } chbp_stat_t;

  // Mask of the low len bits of a code word.
  function automatic logic [MAX_CODE_BITS-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [MAX_CODE_BITS-1:0] m;
    for (int i = 0; i < MAX_CODE_BITS; i++) begin
      m[i] = (i < int'(len));
    end
    return m;
  endfunction

endpackage

// ===== hdl/canonical_huffman_bit_packer.sv =====
// ============================================================================
// Canonical Huffman bit packer
// Packs canonical Huffman code words of byte symbols into a byte stream.
// ============================================================================
// Usage:
// The input channel carries one item per beat: a load writes one entry of
// the code-length table, an encode packs one symbol, a finish packs the end
// symbol, pads with zeros to a byte and flags the last byte as stream end.
// The output channel carries one packed byte per beat; last marks the final
// byte that an item causes. The user must see that the config channel
// writes max_level only while idle; the block does not enforce it. After
// reset the length table is cleared, one entry a cycle, and input stays
// stalled until the clearing pass ends. An encode or finish looks up the
// code, appends it and emits the full bytes; the first one after a load or
// config write also rebuilds the code table first, reading each length
// table entry once per level over a single read port. The output register
// decouples the sides: while the receiver stalls, the held byte stays put
// and the block waits only when it has a next byte.
// ============================================================================
module canonical_huffman_bit_packer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     opcode_i,
  input  logic [chbp_pkg::SYM_W-1:0]     symbol_i,
  input  logic [chbp_pkg::LEN_W-1:0]     code_length_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [chbp_pkg::BYTE_BITS-1:0] out_byte_o,
  output logic                           last_o,
  output logic                           stream_end_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [chbp_pkg::LEN_W-1:0]     cfg_max_level_i
);
  import chbp_pkg::*;

  chbp_cmd_t  cmd;
  chbp_stat_t stat;
  logic       cfg_we;

  // The config register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  chbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (opcode_e'(opcode_i)),
    .cfg_we_i    (cfg_we),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o)
  );

  chbp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (opcode_i),
    .symbol_i        (symbol_i),
    .code_length_i   (code_length_i),
    .cfg_we_i        (cfg_we),
    .cfg_max_level_i (cfg_max_level_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .last_o          (last_o),
    .stream_end_o    (stream_end_o)
  );

endmodule

// ===== hdl/chbp_ram.sv =====
// ============================================================================
// Generic single-clock RAM
// One write port and one read port with a registered read.
// ============================================================================
module chbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/chbp_ctrl.sv =====
// ============================================================================
// Canonical Huffman bit packer: controller
// Sequences the clearing pass, the code rebuild, the table lookup and the
// byte emission of each item.
// ============================================================================
module chbp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  chbp_pkg::opcode_e    in_opcode_i,
  input  logic                 cfg_we_i,
  input  chbp_pkg::chbp_stat_t stat_i,
  output chbp_pkg::chbp_cmd_t  cmd_o,
  output logic                 in_stall_o
);
  import chbp_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RB_LVL,
    ST_RB_RD,
    ST_RB_CHK,
    ST_LOOKUP,
    ST_APPEND,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   tbl_valid_q, tbl_valid_d;
  logic   accept;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands.
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    tbl_valid_d = tbl_valid_q;
    if (cfg_we_i) begin
      tbl_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.scan_last) begin
          cmd_o.scan_rst = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.item_load = 1'b1;
          unique case (in_opcode_i)
            OP_LOAD: begin
              cmd_o.load_wr = 1'b1;
              tbl_valid_d   = 1'b0;
            end
            OP_ENCODE, OP_FINISH: begin
              if (tbl_valid_q) begin
                state_d = ST_LOOKUP;
              end else begin
                cmd_o.lvl_init = 1'b1;
                cmd_o.scan_rst = 1'b1;
                state_d        = ST_RB_LVL;
              end
            end
            OP_NONE: begin
            end
          endcase
        end
      end
      ST_RB_LVL: begin
        if (stat_i.lvl_zero) begin
          tbl_valid_d = 1'b1;
          state_d     = ST_LOOKUP;
        end else begin
          state_d = ST_RB_RD;
        end
      end
      ST_RB_RD: begin
        state_d = ST_RB_CHK;
      end
      ST_RB_CHK: begin
        cmd_o.rb_wr = 1'b1;
        if (stat_i.scan_last) begin
          cmd_o.scan_rst = 1'b1;
          cmd_o.lvl_next = 1'b1;
          state_d        = ST_RB_LVL;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = ST_RB_RD;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_APPEND;
      end
      ST_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat_i.pend_ge8) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last_byte) begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

  // State and table-valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      tbl_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tbl_valid_q <= tbl_valid_d;
    end
  end

endmodule

// ===== hdl/chbp_dp.sv =====
// ============================================================================
// Canonical Huffman bit packer: datapath
// Length and code tables, rebuild counters, bit accumulator and the
// output register.
// ============================================================================
module chbp_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  chbp_pkg::chbp_cmd_t               cmd_i,
  output chbp_pkg::chbp_stat_t              stat_o,
  input  logic [1:0]                        opcode_i,
  input  logic [chbp_pkg::SYM_W-1:0]        symbol_i,
  input  logic [chbp_pkg::LEN_W-1:0]        code_length_i,
  input  logic                              cfg_we_i,
  input  logic [chbp_pkg::LEN_W-1:0]        cfg_max_level_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [chbp_pkg::BYTE_BITS-1:0]    out_byte_o,
  output logic                              last_o,
  output logic                              stream_end_o
);
  import chbp_pkg::*;

  logic [LEN_W-1:0]         max_level_q;
  logic [SYM_W-1:0]         scan_q, scan_d;
  logic [LEN_W-1:0]         lvl_q, lvl_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d, cnt_inc;
  opcode_e                  op_q;
  logic [SYM_W-1:0]         sym_q;
  logic [ACC_W-1:0]         acc_q, acc_d;
  logic [PEND_W-1:0]        pend_q, pend_d;
  logic                     out_valid_q, out_valid_d;
  logic [BYTE_BITS-1:0]     out_byte_q;
  logic                     last_q, end_q;

  logic                     len_we;
  logic [SYM_W-1:0]         len_waddr, len_raddr;
  logic [LEN_W-1:0]         len_wdata, len_rd, len_clamp;
  logic                     code_we;
  logic [MAX_CODE_BITS-1:0] code_wdata, code_rd;
  logic [SYM_W-1:0]         look_addr;
  logic                     look_ok, lvl_match;
  logic [LEN_W-1:0]         lvl_top, len_eff;
  logic [ACC_W-1:0]         code_eff;
  logic [PEND_W-1:0]        total, shift, byte_sh;
  logic [PAD_W-1:0]         pad;

  // Table addressing.
  assign look_addr = (op_q == OP_FINISH) ? SYM_W'(END_SYMBOL) : sym_q;
  assign look_ok   = (op_q == OP_FINISH) || (int'(sym_q) < NUM_SYMBOLS);
  assign len_clamp = (int'(code_length_i) > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS)
                                                           : code_length_i;

  // Length table: cleared after reset, written by load beats.
  assign len_we    = cmd_i.clr_wr || (cmd_i.load_wr && (int'(symbol_i) < NUM_SYMBOLS));
  assign len_waddr = cmd_i.clr_wr ? scan_q : symbol_i;
  assign len_wdata = cmd_i.clr_wr ? '0 : len_clamp;
  assign len_raddr = cmd_i.lookup ? look_addr : scan_q;

  chbp_ram #(
    .WIDTH (LEN_W),
    .DEPTH (NUM_SYMBOLS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .raddr_i (len_raddr),
    .rdata_o (len_rd)
  );

  // Code table: written during a rebuild when the length matches the level.
  assign lvl_match  = (len_rd == lvl_q);
  assign code_we    = cmd_i.rb_wr && lvl_match;
  assign code_wdata = MAX_CODE_BITS'(cnt_q) & len_mask(lvl_q);

  chbp_ram #(
    .WIDTH (MAX_CODE_BITS),
    .DEPTH (NUM_SYMBOLS)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (scan_q),
    .wdata_i (code_wdata),
    .raddr_i (look_addr),
    .rdata_o (code_rd)
  );

  // Rebuild scan, level and code counter.
  assign lvl_top = (int'(max_level_q) > MAX_CODE_BITS) ? LEN_W'(MAX_CODE_BITS)
                                                       : max_level_q;
  assign cnt_inc = cnt_q + CNT_W'(code_we);

  always_comb begin
    scan_d = scan_q;
    lvl_d  = lvl_q;
    cnt_d  = cnt_q;
    if (cmd_i.scan_rst) begin
      scan_d = '0;
    end else if (cmd_i.scan_inc) begin
      scan_d = scan_q + SYM_W'(1);
    end
    if (cmd_i.lvl_init) begin
      lvl_d = lvl_top;
      cnt_d = '0;
    end else if (cmd_i.lvl_next) begin
      lvl_d = lvl_q - LEN_W'(1);
      cnt_d = cnt_inc >> 1;
    end else if (cmd_i.rb_wr) begin
      cnt_d = cnt_inc;
    end
  end

  // Append: shift in the code, and for a finish pad to a byte boundary.
  assign len_eff  = look_ok ? len_rd : '0;
  assign code_eff = ACC_W'(code_rd & len_mask(len_eff));
  assign total    = pend_q + PEND_W'(len_eff);
  assign pad      = (op_q == OP_FINISH) ? PAD_W'(PAD_W'(0) - total[PAD_W-1:0]) : '0;
  assign shift    = PEND_W'(len_eff) + PEND_W'(pad);
  assign byte_sh  = pend_q - PEND_W'(BYTE_BITS);

  always_comb begin
    acc_d  = acc_q;
    pend_d = pend_q;
    if (cmd_i.append) begin
      acc_d  = (acc_q << shift) | (code_eff << pad);
      pend_d = total + PEND_W'(pad);
    end else if (cmd_i.emit) begin
      pend_d = byte_sh;
    end
  end

  // Output register: a new byte may enter as the held one leaves.
  assign out_valid_d = cmd_i.emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_level_q <= LEN_W'(MAX_LEVEL_RESET);
      scan_q      <= '0;
      lvl_q       <= '0;
      cnt_q       <= '0;
      acc_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_level_q <= cfg_max_level_i;
      end
      scan_q      <= scan_d;
      lvl_q       <= lvl_d;
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Captured item and output payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      op_q  <= opcode_e'(opcode_i);
      sym_q <= symbol_i;
    end
    if (cmd_i.emit) begin
      out_byte_q <= BYTE_BITS'(acc_q >> byte_sh);
      last_q     <= (int'(pend_q) < 2 * BYTE_BITS);
      end_q      <= (int'(pend_q) < 2 * BYTE_BITS) && (op_q == OP_FINISH);
    end
  end

  // Status to the controller.
  assign stat_o.scan_last = (int'(scan_q) == NUM_SYMBOLS - 1);
  assign stat_o.lvl_zero  = (lvl_q == '0);
  assign stat_o.pend_ge8  = (int'(pend_q) >= BYTE_BITS);
  assign stat_o.last_byte = (int'(pend_q) < 2 * BYTE_BITS);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign last_o       = last_q;
  assign stream_end_o = end_q;

endmodule

// ===== hdl/chbp_checker.sv =====
// ============================================================================
// Canonical Huffman bit packer: port checker
// Watches the top-level ports over time; bound to the top level.
// ============================================================================
module chbp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [1:0]                     opcode_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [chbp_pkg::BYTE_BITS-1:0] out_byte_o,
  input logic                           last_o,
  input logic                           stream_end_o
);
  import chbp_pkg::*;

  // A stalled output beat holds its byte and flags.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(last_o) && $stable(stream_end_o))
    else $error("stalled output beat changed");

  // The stream-end byte always closes its item.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stream_end_o |-> last_o)
    else $error("stream end without last");

  // While an item still owes bytes, no new item is taken.
  a_busy_mid_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input accepted while an item is still emitting");

  // A load beat produces no output byte.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == OP_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("load produced an output byte");

endmodule

bind canonical_huffman_bit_packer chbp_checker u_chbp_checker (.*);
